[hdl/recent_mac_duplicate_suppressor_top_defines.svh]
// Assertion macros shared by the RTL. Clock clk, reset arst_n (active low).
`ifndef RECENT_MAC_DUPLICATE_SUPPRESSOR_TOP_DEFINES_SVH
`define RECENT_MAC_DUPLICATE_SUPPRESSOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every edge out of reset.
`define RMDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen out of reset.
`define RMDS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define RMDS_ASSERT(lbl, prop, msg)
`define RMDS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[hdl/rmds_pkg.sv]
package rmds_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int MAC_W       = 48;
	localparam int TIME_W      = 32;
	localparam int TIER_W      = 3;
	localparam int WIN_W       = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic [TIER_W-1:0] MIN_TIER_RST = TIER_W'(3);
	localparam logic [WIN_W-1:0]  WINDOW_RST   = WIN_W'(15);

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		OUT_EMIT     = 2'd0,
		OUT_NO_POS   = 2'd1,
		OUT_LOW_TIER = 2'd2,
		OUT_DUP      = 2'd3
	} outcome_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} state_t;

	// Lookup key and running verdict handed from cell to cell.
	typedef struct packed {
		logic              active;
		logic              done;
		logic              hit;
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] now;
	} probe_t;

endpackage

[hdl/rmds_cell.sv]
module rmds_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rmds_pkg::probe_t        probe_in,
	output rmds_pkg::probe_t        probe_out,
	input  logic [rmds_pkg::WIN_W-1:0]  window,
	input  logic                    wr_en,
	input  logic [rmds_pkg::MAC_W-1:0]  wr_mac,
	input  logic [rmds_pkg::TIME_W-1:0] wr_time
);
	import rmds_pkg::*;

	logic [MAC_W-1:0]  mac_q;
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] age;
	logic              match;
	probe_t            probe_d;
	probe_t            probe_s1;
	logic              active_s1;

	// time of zero marks an empty entry
	assign match = probe_in.active && !probe_in.done && (time_q != '0) && (mac_q == probe_in.mac);
	assign age   = probe_in.now - time_q;

	always_comb begin
		probe_d      = probe_in;
		probe_d.done = probe_in.done | match;
		probe_d.hit  = probe_in.hit | (match && (age < TIME_W'(window)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (wr_en) begin
			time_q <= wr_time;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mac_q <= wr_mac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_s1 <= 1'b0;
		end else begin
			active_s1 <= probe_d.active;
		end
	end

	// data half of the probe needs no reset; active comes from the flop above
	always_ff @(posedge clk) begin
		probe_s1 <= probe_d;
	end

	always_comb begin
		probe_out        = probe_s1;
		probe_out.active = active_s1;
	end

endmodule

[hdl/recent_mac_duplicate_suppressor_top.sv]
// Result: an event rejected for position or tier gives its word in the cycle after acceptance;
// a screened event walks the cell chain, one register per cell, then its word is registered.
// Flow: a screened event holds off the next event until its scan is done (one cell per cycle);
// rejected ones are taken one per cycle; a result word left waiting holds off the next event.
// Reset (arst_n, async): table empty, pointer 0, min_tier 3, window_seconds 15, no result.
`include "recent_mac_duplicate_suppressor_top_defines.svh"

module recent_mac_duplicate_suppressor_top #(
	parameter int ENTRIES = rmds_pkg::ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [rmds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rmds_pkg::WIN_W-1:0]     cfg_data,
	// event channel
	input  logic                           event_valid,
	output logic                           event_ready,
	input  logic [rmds_pkg::MAC_W-1:0]     mac,
	input  logic [rmds_pkg::TIER_W-1:0]    tier,
	input  logic                           position_valid,
	input  logic [rmds_pkg::TIME_W-1:0]    now_seconds,
	// result channel
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [1:0]                     outcome
);
	import rmds_pkg::*;

	localparam int PTR_W = $clog2(ENTRIES);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ENTRIES - 1);

	// configuration registers
	logic [TIER_W-1:0] min_tier_q;
	logic [WIN_W-1:0]  window_q;

	// control
	state_t            state_q, state_d;
	logic [PTR_W-1:0]  ptr_q;
	logic              accept;
	logic              is_scan;
	logic              slot_free;
	logic              scan_done;
	logic              wr_fire;

	// result word register
	logic              result_valid_q;
	outcome_t          outcome_q;

	// cell chain: chain[0] is the injected probe, chain[ENTRIES] leaves the last cell
	probe_t            chain [ENTRIES+1];
	probe_t            tail;
	logic [ENTRIES-1:0] act_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_tier_q <= MIN_TIER_RST;
			window_q   <= WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_TIER: min_tier_q <= cfg_data[TIER_W-1:0];
				CFG_WINDOW:   window_q   <= cfg_data;
				default: ;  // unused indexes are dropped
			endcase
		end
	end

	// Output slot frees when the word is taken in this cycle, so a new event
	// can be screened while the old word leaves.
	assign slot_free = !result_valid_q || result_ready;
	assign accept    = event_valid && event_ready;
	// position check wins over the tier check
	assign is_scan   = accept && position_valid && (tier >= min_tier_q);
	assign tail      = chain[ENTRIES];
	assign scan_done = tail.active;
	// a miss or a stale match both insert a new entry at the pointer
	assign wr_fire   = scan_done && !tail.hit;

	always_comb begin
		state_d     = state_q;
		event_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				event_ready = slot_free;
				if (is_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (wr_fire) begin
			ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
		end
	end

	// probe enters cell 0 in the accept cycle
	always_comb begin
		chain[0].active = is_scan;
		chain[0].done   = 1'b0;
		chain[0].hit    = 1'b0;
		chain[0].mac    = mac;
		chain[0].now    = now_seconds;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		rmds_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.probe_in  (chain[i]),
			.probe_out (chain[i+1]),
			.window    (window_q),
			.wr_en     (wr_fire && (ptr_q == PTR_W'(i))),
			.wr_mac    (tail.mac),
			.wr_time   (tail.now)
		);
		assign act_vec[i] = chain[i+1].active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (scan_done || (accept && !is_scan)) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_done) begin
			outcome_q <= tail.hit ? OUT_DUP : OUT_EMIT;
		end else if (accept && !is_scan) begin
			outcome_q <= !position_valid ? OUT_NO_POS : OUT_LOW_TIER;
		end
	end

	assign result_valid = result_valid_q;
	assign outcome      = outcome_q;

	// checks
	`RMDS_ASSERT(a_one_probe, $countones(act_vec) <= 1, "more than one probe in the chain")
	`RMDS_ASSERT(a_scan_state, (state_q == ST_SCAN) == (|act_vec), "scan state and chain disagree")
	`RMDS_ASSERT_NEVER(a_slot_busy, scan_done && result_valid_q, "scan finished into a full slot")
	`RMDS_ASSERT_NEVER(a_ptr_range, ptr_q > PTR_LAST, "write pointer out of range")

endmodule

[bench/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rmds_pkg::*;

	localparam int ENTRIES     = ENTRIES_DEF;
	localparam int SLOT_W      = $clog2(ENTRIES);
	localparam int POOL_N      = 24;      // small MAC pool so repeats hit the table
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 176;
	localparam int LONG_HOLD   = 400;     // result side hold-off, fills the block
	localparam int CYCLE_LIMIT = 400000;

	// indexes past the last register; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

	// One row of the directed table: either a register write or an event.
	// typed=1 means the outcome is written in the row, else the predictor decides.
	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] cfg_idx;
		logic [WIN_W-1:0]     cfg_val;
		logic [MAC_W-1:0]     mac;
		logic [TIER_W-1:0]    tier;
		logic                 pos;
		logic [TIME_W-1:0]    now;
		logic                 typed;
		logic [1:0]           want;
	} dir_row_t;

	localparam int DIR_N = 32;

	// Starts from reset: min_tier 3, window 15, table empty.
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// no position, top tier
		'{mac: 48'hFFFFFFFFFFFF, tier: 3'd7, pos: 1'b0, now: 32'd100, typed: 1'b1,
			want: OUT_NO_POS, default: '0},
		// no position and low tier: position wins
		'{mac: 48'h0, tier: 3'd0, pos: 1'b0, now: 32'd0, typed: 1'b1,
			want: OUT_NO_POS, default: '0},
		'{mac: 48'h0, tier: 3'd2, pos: 1'b1, now: 32'd5, typed: 1'b1,
			want: OUT_LOW_TIER, default: '0},
		// empty table: first live event goes through
		'{mac: 48'h0, tier: 3'd3, pos: 1'b1, now: 32'd1, typed: 1'b1,
			want: OUT_EMIT, default: '0},
		// age 14 inside window of 15
		'{mac: 48'h0, tier: 3'd3, pos: 1'b1, now: 32'd15, typed: 1'b1,
			want: OUT_DUP, default: '0},
		// age exactly the window
		'{mac: 48'h0, tier: 3'd7, pos: 1'b1, now: 32'd16, default: '0},
		// two live copies now; only the older, first one counts
		'{mac: 48'h0, tier: 3'd7, pos: 1'b1, now: 32'd17, default: '0},
		// stored at time zero: entry stays empty
		'{mac: 48'hFFFFFFFFFFFF, tier: 3'd7, pos: 1'b1, now: 32'd0, typed: 1'b1,
			want: OUT_EMIT, default: '0},
		'{mac: 48'hFFFFFFFFFFFF, tier: 3'd7, pos: 1'b1, now: 32'd1, default: '0},
		'{mac: 48'hFFFFFFFFFFFF, tier: 3'd7, pos: 1'b1, now: 32'd2, default: '0},
		// age across the 32-bit wrap
		'{mac: 48'h800000000001, tier: 3'd4, pos: 1'b1, now: 32'hFFFFFFF8, default: '0},
		'{mac: 48'h800000000001, tier: 3'd4, pos: 1'b1, now: 32'd4, default: '0},
		'{mac: 48'h7FFFFFFFFFFE, tier: 3'd5, pos: 1'b1, now: 32'hFFFFFFFF, default: '0},
		'{is_cfg: 1'b1, cfg_idx: CFG_SPARE_A, cfg_val: 16'hFFFF, default: '0},
		'{is_cfg: 1'b1, cfg_idx: CFG_SPARE_B, cfg_val: 16'h0000, default: '0},
		// min_tier must still be 3
		'{mac: 48'h000000000002, tier: 3'd2, pos: 1'b1, now: 32'd30, typed: 1'b1,
			want: OUT_LOW_TIER, default: '0},
		'{mac: 48'h800000000001, tier: 3'd4, pos: 1'b1, now: 32'd10, default: '0},
		'{is_cfg: 1'b1, cfg_idx: CFG_MIN_TIER, cfg_val: 16'd0, default: '0},
		'{is_cfg: 1'b1, cfg_idx: CFG_WINDOW, cfg_val: 16'd0, default: '0},
		// zero window: same MAC, same second, never suppressed
		'{mac: 48'h000000000002, tier: 3'd0, pos: 1'b1, now: 32'd40, default: '0},
		'{mac: 48'h000000000002, tier: 3'd0, pos: 1'b1, now: 32'd40, default: '0},
		'{mac: 48'h0, tier: 3'd0, pos: 1'b0, now: 32'd41, typed: 1'b1,
			want: OUT_NO_POS, default: '0},
		'{is_cfg: 1'b1, cfg_idx: CFG_MIN_TIER, cfg_val: 16'd7, default: '0},
		'{is_cfg: 1'b1, cfg_idx: CFG_WINDOW, cfg_val: 16'hFFFF, default: '0},
		'{mac: 48'h000000000003, tier: 3'd6, pos: 1'b1, now: 32'd100, typed: 1'b1,
			want: OUT_LOW_TIER, default: '0},
		'{mac: 48'h000000000003, tier: 3'd7, pos: 1'b1, now: 32'd100, default: '0},
		// widest window: last second inside, then first second outside
		'{mac: 48'h000000000003, tier: 3'd7, pos: 1'b1, now: 32'd65634, default: '0},
		'{mac: 48'h000000000003, tier: 3'd7, pos: 1'b1, now: 32'd65635, default: '0},
		// upper bits of min_tier data are dropped: 0xFFF9 gives 1
		'{is_cfg: 1'b1, cfg_idx: CFG_MIN_TIER, cfg_val: 16'hFFF9, default: '0},
		'{is_cfg: 1'b1, cfg_idx: CFG_WINDOW, cfg_val: 16'd15, default: '0},
		'{mac: 48'h000000000004, tier: 3'd0, pos: 1'b1, now: 32'd200, default: '0},
		'{mac: 48'h000000000004, tier: 3'd1, pos: 1'b1, now: 32'd200, default: '0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WIN_W-1:0]     cfg_data;
	logic                 event_valid;
	logic                 event_ready;
	logic [MAC_W-1:0]     mac;
	logic [TIER_W-1:0]    tier;
	logic                 position_valid;
	logic [TIME_W-1:0]    now_seconds;
	logic                 result_valid;
	logic                 result_ready;
	logic [1:0]           outcome;

	// outcome written in a directed row travels with the word it belongs to
	logic                 use_typed;
	outcome_t             typed_outcome;

	// predictor copy of the block
	logic [MAC_W-1:0]     seen_mac  [ENTRIES] = '{default: '0};
	logic [TIME_W-1:0]    seen_time [ENTRIES] = '{default: '0};
	logic [SLOT_W-1:0]    next_slot    = '0;
	logic [TIER_W-1:0]    cur_min_tier = MIN_TIER_RST;
	logic [WIN_W-1:0]     cur_window   = WINDOW_RST;

	outcome_t             pending_outcomes [$];
	int unsigned          n_sent  = 0;
	int unsigned          n_done  = 0;
	int unsigned          fails   = 0;
	int unsigned          idle_pct = 0;   // percent chance of starting an idle burst, per event sent and per sink check
	bit                   hold_off_go = 1'b0;
	logic [MAC_W-1:0]     mac_pool [POOL_N];

	recent_mac_duplicate_suppressor_top #(.ENTRIES(ENTRIES)) u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Screen one event and update the table the same way the block must.
	function automatic outcome_t screen_event(input logic [MAC_W-1:0] m,
			input logic [TIER_W-1:0] t, input logic p, input logic [TIME_W-1:0] s);
		int hit;
		hit = -1;
		if (!p)
			return OUT_NO_POS;
		if (t < cur_min_tier)
			return OUT_LOW_TIER;
		// first live match in index order, nothing after it
		for (int i = 0; i < ENTRIES; i++)
			if (hit < 0 && seen_time[i] != '0 && seen_mac[i] == m)
				hit = i;
		if (hit >= 0 && TIME_W'(s - seen_time[hit]) < TIME_W'(cur_window))
			return OUT_DUP;
		seen_mac[next_slot]  = m;
		seen_time[next_slot] = s;
		next_slot            = next_slot + 1'b1;
		return OUT_EMIT;
	endfunction

	// Config writes, accepted events and result words, all seen at one edge in
	// a fixed order so a word leaving as a new event is taken cannot race.
	always @(posedge clk) begin : outcome_check
		outcome_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_TIER: cur_min_tier = cfg_data[TIER_W-1:0];
					CFG_WINDOW:   cur_window   = cfg_data;
					default: ;
				endcase
			end
			if (event_valid && event_ready) begin
				want = screen_event(mac, tier, position_valid, now_seconds);
				pending_outcomes.push_back(use_typed ? typed_outcome : want);
			end
			if (result_valid && result_ready) begin
				n_done++;
				if (pending_outcomes.size() == 0) begin
					$error("outcome: word %0d arrived with no event waiting", outcome);
					fails++;
				end else begin
					want = pending_outcomes.pop_front();
					if (outcome !== want) begin
						$error("outcome: expected %0d (%s), got %0d", want, want.name(), outcome);
						fails++;
					end
				end
			end
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			if (hold_off_go) begin
				hold_off_go = 1'b0;
				stall_left  = LONG_HOLD;
			end else if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(1, 12);
			end
			if (stall_left != 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
			end
			@(posedge clk);
		end
	end

	// Hard stop if the block hangs.
	initial begin : cycle_guard
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// Present one event, hold it until taken, then maybe idle a burst.
	task automatic offer_event(input logic [MAC_W-1:0] m, input logic [TIER_W-1:0] t,
			input logic p, input logic [TIME_W-1:0] s, input logic typed, input outcome_t want);
		event_valid    <= 1'b1;
		mac            <= m;
		tier           <= t;
		position_valid <= p;
		now_seconds    <= s;
		use_typed      <= typed;
		typed_outcome  <= want;
		@(posedge clk);
		while (!event_ready)
			@(posedge clk);
		n_sent++;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			event_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every outstanding word, plus scan time.
	task automatic await_drain();
		event_valid <= 1'b0;
		@(posedge clk);
		while (n_done != n_sent)
			@(posedge clk);
		repeat (ENTRIES + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		logic [MAC_W-1:0]  m;
		logic [TIER_W-1:0] t;
		logic              p;
		logic [TIME_W-1:0] s;
		logic [TIME_W-1:0] clock_now;
		int unsigned       mt, win, pool_used, r;

		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= CFG_MIN_TIER;
		cfg_data       <= '0;
		event_valid    <= 1'b0;
		mac            <= '0;
		tier           <= '0;
		position_valid <= 1'b0;
		now_seconds    <= '0;
		use_typed      <= 1'b0;
		typed_outcome  <= OUT_EMIT;

		// pool keeps both all-zero and all-one addresses
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		for (int i = 2; i < POOL_N; i++)
			mac_pool[i] = MAC_W'({$urandom, $urandom});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; registers only change once the block is empty
		idle_pct = 35;
		for (int i = 0; i < DIR_N; i++) begin
			if (DIR_ROWS[i].is_cfg) begin
				await_drain();
				write_reg(DIR_ROWS[i].cfg_idx, DIR_ROWS[i].cfg_val);
			end else begin
				offer_event(DIR_ROWS[i].mac, DIR_ROWS[i].tier, DIR_ROWS[i].pos,
					DIR_ROWS[i].now, DIR_ROWS[i].typed, outcome_t'(DIR_ROWS[i].want));
			end
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			await_drain();
			case (ph)
				0: begin
					mt  = MIN_TIER_RST;
					win = WINDOW_RST;
				end
				1: begin
					mt  = 0;
					win = 0;
				end
				2: begin
					mt  = 7;
					win = 32'hFFFF;
				end
				3: begin
					mt  = $urandom_range(0, 7);
					win = $urandom_range(1, 40);
				end
				4: begin
					mt  = $urandom_range(0, 4);
					win = $urandom_range(16, 64);
				end
				5: begin
					mt  = $urandom_range(0, 7);
					win = $urandom_range(0, 65535);
				end
				default: begin
					mt  = $urandom_range(0, 5);
					win = $urandom_range(4, 30);
				end
			endcase
			// junk above bit 2 checks the width mask on min_tier
			write_reg(CFG_MIN_TIER, {13'($urandom), TIER_W'(mt)});
			write_reg(CFG_WINDOW, WIN_W'(win));
			pool_used = $urandom_range(4, POOL_N);
			// one phase starts just short of the time wrap
			clock_now = (ph == 2) ? 32'hFFFFFF80 : TIME_W'($urandom_range(1, 100000));

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 60 == 0) begin
					if (ph == PHASES - 1) begin
						idle_pct = 0;
					end else begin
						case ($urandom_range(0, 3))
							0: idle_pct = 0;
							1: idle_pct = 10;
							2: idle_pct = 35;
							default: idle_pct = 70;
						endcase
					end
				end
				if (ph == 3 && k == 40)
					hold_off_go = 1'b1;
				// sender pause until the block is empty
				if (ph == 4 && k == 90)
					await_drain();

				r = $urandom_range(0, 99);
				clock_now += $urandom_range(0, 3);
				if (r == 0)
					clock_now += $urandom;
				if (r < 10) begin
					// noise: every field fully random
					m = MAC_W'({$urandom, $urandom});
					t = TIER_W'($urandom_range(0, 7));
					p = 1'($urandom_range(0, 1));
					s = $urandom;
				end else begin
					// mostly well-formed repeats from the pool
					m = mac_pool[$urandom_range(0, pool_used - 1)];
					t = (r < 18) ? TIER_W'($urandom_range(0, 7)) : TIER_W'($urandom_range(mt, 7));
					p = (r >= 14);
					s = clock_now;
				end
				offer_event(m, t, p, s, 1'b0, OUT_EMIT);
			end
		end

		await_drain();
		if (fails == 0 && pending_outcomes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/rmds_pkg.sv
hdl/rmds_cell.sv
hdl/recent_mac_duplicate_suppressor_top.sv
bench/tb.sv
